### rtl/core/rrv_pkg.sv
// ----------------------------------------------------------------------------
// rrv_pkg
// Shared types and constants of the red radial vignette pipeline.
// ----------------------------------------------------------------------------
package rrv_pkg;

   // field widths
   localparam int XY_W      = 12;
   localparam int PIX_W     = 32;
   localparam int DIM_W     = 13;
   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT  = 2'd2;

   // register reset values
   localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd960;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd544;

   // pixel formats
   localparam logic FMT_RGBA8888 = 1'b0;
   localparam logic FMT_RGB565   = 1'b1;

   // reciprocal 2^24 / half size
   localparam int RECIP_SHIFT = 24;
   localparam int QUO_W       = RECIP_SHIFT + 1;
   localparam int DIST_SHIFT  = 16;
   localparam int D2_SHIFT    = 8;

   // smoothstep shaping
   localparam int T_OFFSET   = 64;
   localparam int WEIGHT_MAX = 256;
   localparam int SMOOTH_K   = 768;
   localparam int T_W        = 9;
   localparam int V_W        = 9;
   localparam int WGT_SHIFT  = 16;

   // colour constants
   localparam logic [7:0] RED_TGT_8888 = 8'd100;
   localparam logic [7:0] RED_TGT_565  = 8'd12;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] MAX_8BIT     = 8'd255;
   localparam logic [7:0] MAX_5BIT     = 8'd31;
   localparam logic [7:0] MAX_6BIT     = 8'd63;

   // pipeline stages
   localparam int NUM_STAGES = 8;
   localparam int ST_DIFF    = 0;
   localparam int ST_PROD    = 1;
   localparam int ST_SQR     = 2;
   localparam int ST_THR     = 3;
   localparam int ST_TSQ     = 4;
   localparam int ST_WGT     = 5;
   localparam int ST_MUL     = 6;
   localparam int ST_OUT     = 7;

   typedef logic [NUM_STAGES-1:0] stage_vec_type;

   typedef struct packed {
      logic             busy;
      logic [QUO_W-1:0] inv;
   } recip_status_type;

endpackage

### rtl/core/rrv_recip.sv
// ----------------------------------------------------------------------------
// rrv_recip
// Clamps one screen dimension, halves it and divides 2^24 by the half size,
// one quotient bit per cycle (restoring division).
// ----------------------------------------------------------------------------
module rrv_recip
   import rrv_pkg::*;
#(
   parameter int MAX_SCREEN_DIM = 4096
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     restart,
   input  logic [DIM_W-1:0]                         dim,
   output logic [$clog2(MAX_SCREEN_DIM / 2 + 1)-1:0] half,
   output recip_status_type                         status
);

   localparam int LIM_W  = $clog2(MAX_SCREEN_DIM + 1);
   localparam int CMP_W  = (LIM_W > DIM_W) ? LIM_W : DIM_W;
   localparam int HALF_W = $clog2(MAX_SCREEN_DIM / 2 + 1);
   localparam int CNT_W  = $clog2(QUO_W);

   logic [CMP_W-1:0]  dim_ext;
   logic [CMP_W-1:0]  dim_clamped;
   logic [HALF_W:0]   rem_shift;
   logic              next_bit;
   logic              fits;
   logic [HALF_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   always_comb begin
      dim_ext = CMP_W'(dim);
      if (dim_ext < CMP_W'(2)) begin
         dim_clamped = CMP_W'(2);
      end else if (dim_ext > CMP_W'(MAX_SCREEN_DIM)) begin
         dim_clamped = CMP_W'(MAX_SCREEN_DIM);
      end else begin
         dim_clamped = dim_ext;
      end
   end

   assign half = dim_clamped[HALF_W:1];

   // dividend is 2^24: a single one at the first step, zeros after
   assign next_bit  = (cnt_ff == '0);
   assign rem_shift = {rem_ff, next_bit};
   assign fits      = (rem_shift >= {1'b0, half});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (restart) begin
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = HALF_W'(rem_shift - {1'b0, half});
         end else begin
            rem_in = rem_shift[HALF_W-1:0];
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.inv  = quo_ff;

endmodule

### rtl/core/rrv_dist.sv
// ----------------------------------------------------------------------------
// rrv_dist
// Normalised distance from the screen centre: offset, scale, square,
// sum and threshold into the smoothstep argument t (stages 0 to 3).
// ----------------------------------------------------------------------------
module rrv_dist
   import rrv_pkg::*;
#(
   parameter int MAX_SCREEN_DIM = 4096
) (
   input  logic                                     clock,
   input  stage_vec_type                            en,
   input  logic [XY_W-1:0]                          x_pos,
   input  logic [XY_W-1:0]                          y_pos,
   input  logic [$clog2(MAX_SCREEN_DIM / 2 + 1)-1:0] half_w,
   input  logic [$clog2(MAX_SCREEN_DIM / 2 + 1)-1:0] half_h,
   input  logic [QUO_W-1:0]                         inv_w,
   input  logic [QUO_W-1:0]                         inv_h,
   output logic [T_W-1:0]                           t_out
);

   localparam int HALF_W = $clog2(MAX_SCREEN_DIM / 2 + 1);
   localparam int DIFF_W = ((XY_W > HALF_W) ? XY_W : HALF_W) + 1;
   localparam int PROD_W = DIFF_W + QUO_W + 1;
   localparam int DX_W   = PROD_W - DIST_SHIFT;
   localparam int SQ_W   = 2 * DX_W;
   localparam int SUM_W  = SQ_W + 1;

   logic signed [DIFF_W-1:0] dx_diff_ff, dy_diff_ff, dx_diff_in, dy_diff_in;
   logic signed [PROD_W-1:0] px_ff, py_ff, px_in, py_in;
   logic signed [DX_W-1:0]   dx, dy;
   logic signed [SQ_W-1:0]   sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [SUM_W-1:0]         sum;
   logic [SUM_W-1:0]         d2;
   logic [SUM_W-1:0]         excess;
   logic [T_W-1:0]           t_ff, t_in;

   // stage 0: offset from centre
   assign dx_diff_in = signed'(DIFF_W'(x_pos)) - signed'(DIFF_W'(half_w));
   assign dy_diff_in = signed'(DIFF_W'(y_pos)) - signed'(DIFF_W'(half_h));

   // stage 1: scale by reciprocal of half size
   assign px_in = PROD_W'(dx_diff_ff) * PROD_W'(signed'({1'b0, inv_w}));
   assign py_in = PROD_W'(dy_diff_ff) * PROD_W'(signed'({1'b0, inv_h}));

   // stage 2: squares (shift floors toward minus infinity)
   assign dx     = DX_W'(px_ff >>> DIST_SHIFT);
   assign dy     = DX_W'(py_ff >>> DIST_SHIFT);
   assign sqx_in = SQ_W'(dx) * SQ_W'(dx);
   assign sqy_in = SQ_W'(dy) * SQ_W'(dy);

   // stage 3: threshold, halve, saturate
   assign sum    = unsigned'(SUM_W'(sqx_ff)) + unsigned'(SUM_W'(sqy_ff));
   assign d2     = sum >> D2_SHIFT;
   assign excess = (d2 - SUM_W'(T_OFFSET)) >> 1;

   always_comb begin
      if (d2 < SUM_W'(T_OFFSET)) begin
         t_in = '0;
      end else if (excess > SUM_W'(WEIGHT_MAX)) begin
         t_in = T_W'(WEIGHT_MAX);
      end else begin
         t_in = excess[T_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_DIFF]) begin
         dx_diff_ff <= dx_diff_in;
         dy_diff_ff <= dy_diff_in;
      end
      if (en[ST_PROD]) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (en[ST_SQR]) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
      end
      if (en[ST_THR]) begin
         t_ff <= t_in;
      end
   end

   assign t_out = t_ff;

endmodule

### rtl/core/rrv_weight.sv
// ----------------------------------------------------------------------------
// rrv_weight
// Integer smoothstep: v = t*t*(768 - 2t) >> 16 (stages 4 and 5).
// ----------------------------------------------------------------------------
module rrv_weight
   import rrv_pkg::*;
(
   input  logic           clock,
   input  stage_vec_type  en,
   input  logic [T_W-1:0] t_in,
   output logic [V_W-1:0] v_out
);

   localparam int TSQ_W = 2 * T_W;
   localparam int K_W   = T_W + 1;
   localparam int WP_W  = TSQ_W + K_W;

   logic [TSQ_W-1:0] tsq_ff, tsq_in;
   logic [T_W-1:0]   t_d_ff;
   logic [K_W-1:0]   slope;
   logic [WP_W-1:0]  wprod;
   logic [V_W-1:0]   v_ff;

   assign tsq_in = TSQ_W'(t_in) * TSQ_W'(t_in);
   assign slope  = K_W'(SMOOTH_K) - {t_d_ff, 1'b0};
   assign wprod  = WP_W'(tsq_ff) * WP_W'(slope);

   always_ff @(posedge clock) begin
      if (en[ST_TSQ]) begin
         tsq_ff <= tsq_in;
         t_d_ff <= t_in;
      end
      if (en[ST_WGT]) begin
         v_ff <= wprod[WGT_SHIFT +: V_W];
      end
   end

   assign v_out = v_ff;

endmodule

### rtl/core/rrv_shade.sv
// ----------------------------------------------------------------------------
// rrv_shade
// Colour blend: red toward its target, green and blue darkened, clamp and
// repack (stages 6 and 7).
// ----------------------------------------------------------------------------
module rrv_shade
   import rrv_pkg::*;
(
   input  logic             clock,
   input  stage_vec_type    en,
   input  logic             fmt,
   input  logic [PIX_W-1:0] pixel,
   input  logic [V_W-1:0]   v,
   output logic [PIX_W-1:0] pixel_out
);

   localparam int RD_W  = 9;
   localparam int RM_W  = RD_W + V_W + 1;
   localparam int GM_W  = 8 + V_W;
   localparam int RS_W  = 12;

   logic [7:0]             r8, g8, b8, tgt;
   logic signed [RD_W-1:0] rdelta;
   logic [V_W-1:0]         inv_v;
   logic signed [RM_W-1:0] rmul_ff, rmul_in;
   logic [GM_W-1:0]        gmul_ff, gmul_in, bmul_ff, bmul_in;
   logic [7:0]             r_ff;
   logic signed [RS_W-1:0] rsum;
   logic [GM_W-9:0]        gsh, bsh;
   logic [7:0]             rmax, gmax, nr, ng, nb;
   logic [PIX_W-1:0]       out_ff, out_in;

   // stage 6: unpack and multiply
   always_comb begin
      if (fmt == FMT_RGB565) begin
         r8  = {3'b000, pixel[15:11]};
         g8  = {2'b00, pixel[10:5]};
         b8  = {3'b000, pixel[4:0]};
         tgt = RED_TGT_565;
      end else begin
         r8  = pixel[31:24];
         g8  = pixel[23:16];
         b8  = pixel[15:8];
         tgt = RED_TGT_8888;
      end
   end

   assign rdelta  = signed'({1'b0, tgt}) - signed'({1'b0, r8});
   assign inv_v   = V_W'(WEIGHT_MAX) - v;
   assign rmul_in = RM_W'(rdelta) * RM_W'(signed'({1'b0, v}));
   assign gmul_in = GM_W'(g8) * GM_W'(inv_v);
   assign bmul_in = GM_W'(b8) * GM_W'(inv_v);

   // stage 7: shift, clamp, pack
   assign rmax = (fmt == FMT_RGB565) ? MAX_5BIT : MAX_8BIT;
   assign gmax = (fmt == FMT_RGB565) ? MAX_6BIT : MAX_8BIT;
   assign rsum = signed'(RS_W'(r_ff)) + RS_W'(rmul_ff >>> 8);
   assign gsh  = gmul_ff[GM_W-1:8];
   assign bsh  = bmul_ff[GM_W-1:8];

   always_comb begin
      if (rsum < 0) begin
         nr = '0;
      end else if (rsum > signed'(RS_W'(rmax))) begin
         nr = rmax;
      end else begin
         nr = rsum[7:0];
      end
      ng = (gsh > (GM_W-8)'(gmax)) ? gmax : gsh[7:0];
      nb = (bsh > (GM_W-8)'(rmax)) ? rmax : bsh[7:0];
      if (fmt == FMT_RGB565) begin
         out_in = {16'h0000, nr[4:0], ng[5:0], nb[4:0]};
      end else begin
         out_in = {nr, ng, nb, ALPHA_OPAQUE};
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         rmul_ff <= rmul_in;
         gmul_ff <= gmul_in;
         bmul_ff <= bmul_in;
         r_ff    <= r8;
      end
      if (en[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign pixel_out = out_ff;

endmodule

### rtl/core/red_radial_vignette.sv
// ----------------------------------------------------------------------------
// red_radial_vignette
// Red-tinted radial vignette on a pixel stream with screen coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one pixel and its x,y position per transfer.
//   rsp_*  : the vignetted pixel, same format, one per request, in order.
//   csr_*  : register writes (0 width, 1 height, 2 pixel format); always
//            ready. Unknown indexes are dropped.
// Throughput is one pixel per clock while rsp_ready is high and neither
// divider is busy: eight register stages, each holding a valid bit, and a
// stage takes a new item whenever it is empty or its item moves on, so
// bubbles close up and a stalled rsp side still lets the front fill. A
// result is offered from the output register once it has passed every
// stage; rsp_ready low holds the output register and backs the pipeline
// up stage by stage, nothing is dropped. After reset both bit-serial
// dividers, and after a width or height write its own divider, form
// 2^24 / half-size; req_ready stays low while any divider runs. Reset
// loads 960 x 544, RGBA8888, and empties the pipeline.
module red_radial_vignette
   import rrv_pkg::*;
#(
   parameter int MAX_SCREEN_DIM = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [XY_W-1:0]      req_x_pos,
   input  logic [XY_W-1:0]      req_y_pos,
   input  logic [PIX_W-1:0]     req_pixel_in,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [PIX_W-1:0]     rsp_pixel_out,
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_data
);

   localparam int HALF_W = $clog2(MAX_SCREEN_DIM / 2 + 1);

   // configuration registers
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             fmt_ff, fmt_in;
   logic             csr_xfer;
   logic             restart_w, restart_h;

   // reciprocal units
   recip_status_type  recip_w, recip_h;
   logic [HALF_W-1:0] half_w, half_h;
   logic              recip_busy;

   // pipeline control
   stage_vec_type    valid_ff, valid_in;
   stage_vec_type    stage_ready;
   logic [PIX_W-1:0] pix_ff [ST_WGT+1];
   logic [T_W-1:0]   t_val;
   logic [V_W-1:0]   weight_v;

   // ---------------------------------------------------------------------
   // Register writes; a new width or height restarts its divider
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;
   assign restart_w = csr_xfer && (csr_index == CSR_SCREEN_WIDTH);
   assign restart_h = csr_xfer && (csr_index == CSR_SCREEN_HEIGHT);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      fmt_in    = fmt_ff;
      if (csr_xfer) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_data;
            CSR_SCREEN_HEIGHT: height_in = csr_data;
            CSR_PIXEL_FORMAT:  fmt_in    = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         fmt_ff    <= FMT_RGBA8888;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         fmt_ff    <= fmt_in;
      end
   end

   rrv_recip #(
      .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
   ) u_recip_w (
      .clock   (clock),
      .reset   (reset),
      .restart (restart_w),
      .dim     (width_ff),
      .half    (half_w),
      .status  (recip_w)
   );

   rrv_recip #(
      .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
   ) u_recip_h (
      .clock   (clock),
      .reset   (reset),
      .restart (restart_h),
      .dim     (height_ff),
      .half    (half_h),
      .status  (recip_h)
   );

   assign recip_busy = recip_w.busy || recip_h.busy;

   // ---------------------------------------------------------------------
   // Stage handshake: a stage loads when empty or when its item leaves
   // ---------------------------------------------------------------------
   always_comb begin
      stage_ready[ST_OUT] = !valid_ff[ST_OUT] || rsp_ready;
      for (int k = ST_OUT - 1; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
   end

   assign req_ready = stage_ready[ST_DIFF] && !recip_busy;

   always_comb begin
      valid_in = valid_ff;
      if (stage_ready[ST_DIFF]) begin
         valid_in[ST_DIFF] = req_valid && !recip_busy;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // pixel rides alongside the distance and weight stages
   always_ff @(posedge clock) begin
      if (stage_ready[ST_DIFF]) begin
         pix_ff[ST_DIFF] <= req_pixel_in;
      end
      for (int k = 1; k <= ST_WGT; k++) begin
         if (stage_ready[k]) begin
            pix_ff[k] <= pix_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Datapath
   // ---------------------------------------------------------------------
   rrv_dist #(
      .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
   ) u_dist (
      .clock  (clock),
      .en     (stage_ready),
      .x_pos  (req_x_pos),
      .y_pos  (req_y_pos),
      .half_w (half_w),
      .half_h (half_h),
      .inv_w  (recip_w.inv),
      .inv_h  (recip_h.inv),
      .t_out  (t_val)
   );

   rrv_weight u_weight (
      .clock (clock),
      .en    (stage_ready),
      .t_in  (t_val),
      .v_out (weight_v)
   );

   rrv_shade u_shade (
      .clock     (clock),
      .en        (stage_ready),
      .fmt       (fmt_ff),
      .pixel     (pix_ff[ST_WGT]),
      .v         (weight_v),
      .pixel_out (rsp_pixel_out)
   );

   assign rsp_valid = valid_ff[ST_OUT];

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a size change must block requests until the divider has finished
   a_size_write_blocks: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       (csr_index == CSR_SCREEN_WIDTH || csr_index == CSR_SCREEN_HEIGHT))
      |=> !req_ready)
      else $error("request taken while reciprocal was being recomputed");

   // a blocked multiply stage keeps its item
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_MUL] && !stage_ready[ST_MUL]) |=> valid_ff[ST_MUL])
      else $error("item lost from a stalled stage");

   // smoothstep weight stays within 0..256
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[ST_WGT] |-> (weight_v <= V_W'(WEIGHT_MAX)))
      else $error("vignette weight out of range");

   // RGBA results carry an opaque alpha byte
   a_alpha_opaque: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && fmt_ff == FMT_RGBA8888) |-> (rsp_pixel_out[7:0] == ALPHA_OPAQUE))
      else $error("alpha byte not forced opaque");

endmodule
